/* hw/rtl/cupt_pkg.sv */
// Shared types, codes and helpers for the catch-up pacing timer.
`timescale 1ns / 1ps

package cupt_pkg;

   // Operation codes carried in req_kind
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_POLL  = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   localparam logic [31:0] HALF_RANGE   = 32'h7FFF_FFFF;
   localparam logic [15:0] INTERVAL_RST = 16'd20;
   localparam logic [15:0] PENDING_MAX  = 16'hFFFF;
   localparam int          DIV_STEPS    = 32;

   // CSR register indexes
   localparam logic REG_INTERVAL = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_CATCH,
      ST_MEASURE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;       // capture the incoming item
      logic exec;       // simple update for start, stop, clear and plain poll
      logic div_start;  // seed the divider with the elapsed time
      logic div_step;   // one restoring-division step
      logic catch_up;   // queue the owed slots, move the mark, take one
      logic measure;    // register elapsed time for the remaining figure
      logic publish;    // load the result register
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       running;
      logic       pending_nz;
      logic       overdue;   // elapsed exceeds the interval
      logic       div_last;
      logic       out_busy;  // result register still held by the consumer
   } sts_type;

   // Elapsed time with the wrap rule: one less when the mark sits in the
   // upper half and now in the lower half.
   function automatic logic [31:0] elapsed_since(input logic [31:0] mark,
                                                 input logic [31:0] now);
      logic [31:0] diff;
      diff = now - mark;
      if (mark > HALF_RANGE && now < HALF_RANGE) begin
         diff = diff - 32'd1;
      end
      return diff;
   endfunction

endpackage

/* hw/rtl/catch_up_pacing_timer.sv */
// Sequence: start, stop, clear and any poll other than a catch-up poll pass through
// execute, measure and output; a catch-up poll adds the 32-step serial divider and the
// catch-up state between execute and measure. Flow: one item at a time, the next item
// taken the cycle after loading the result; the divider gives one quotient bit per cycle.
// Reset (synchronous, active high): timer stopped, mark 0, no slots queued, interval 20 ms,
// no result held.
`timescale 1ns / 1ps

module catch_up_pacing_timer
   import cupt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_now_ms,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_send_now,
   output logic [15:0] rsp_remaining_ms,
   output logic [15:0] rsp_pending_slots,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cmd_type     cmd;
   sts_type     sts;
   logic        cfg_we;
   logic [15:0] interval;

   // Zero-wait port; the interval register answers wherever paddr[2] is low (bytes 0 to 3),
   // addresses 4 to 7 read as zero and ignore writes.
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_INTERVAL);
   assign csr_prdata = (csr_paddr[2] == REG_INTERVAL) ? {16'd0, interval} : 32'd0;

   // Sequencer: accept, execute or divide, measure, publish
   cupt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Timer state, divider and the result register
   cupt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_kind),
      .req_now_ms        (req_now_ms),
      .cfg_we            (cfg_we),
      .cfg_data          (csr_pwdata[15:0]),
      .interval          (interval),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_send_now      (rsp_send_now),
      .rsp_remaining_ms  (rsp_remaining_ms),
      .rsp_pending_slots (rsp_pending_slots)
   );

endmodule

/* hw/rtl/cupt_ctrl.sv */
// Sequencer for the pacing timer: steps one item through the datapath.
`timescale 1ns / 1ps

module cupt_ctrl
   import cupt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.kind == KIND_POLL && sts.running && !sts.pending_nz && sts.overdue) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_MEASURE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_CATCH;
            end
         end
         ST_CATCH: begin
            cmd.catch_up = 1'b1;
            state_in     = ST_MEASURE;
         end
         ST_MEASURE: begin
            cmd.measure = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (!sts.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/cupt_dp.sv */
// Datapath for the pacing timer: timer state, serial divider, result register.
`timescale 1ns / 1ps

module cupt_dp
   import cupt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_now_ms,
   input  logic        cfg_we,
   input  logic [15:0] cfg_data,
   output logic [15:0] interval,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic        rsp_send_now,
   output logic [15:0] rsp_remaining_ms,
   output logic [15:0] rsp_pending_slots
);

   logic [1:0]  kind_ff;
   logic [31:0] now_ff;
   logic        running_ff;
   logic [31:0] mark_ff;
   logic [15:0] pending_ff;
   logic [15:0] interval_ff;
   logic        send_ff;
   logic [31:0] elapsed_ff;
   logic [31:0] quo_ff;
   logic [15:0] rem_ff;
   logic [4:0]  cnt_ff;
   logic        rsp_valid_ff;
   logic        rsp_send_ff;
   logic [15:0] rsp_remain_ff;
   logic [15:0] rsp_pending_ff;

   logic [31:0] elapsed_now;
   logic [16:0] rem_sh;
   logic [17:0] rem_diff;
   logic        rem_ge;
   logic [32:0] sum;
   logic [15:0] sat;
   logic        take;
   logic [32:0] used;
   logic [15:0] remain;

   assign elapsed_now = elapsed_since(mark_ff, now_ff);

   // restoring division step
   assign rem_sh   = {rem_ff, quo_ff[31]};
   assign rem_diff = {1'b0, rem_sh} - {2'b00, interval_ff};
   assign rem_ge   = !rem_diff[17];

   // catch-up: add owed slots with saturation, then take one
   assign sum  = {17'd0, pending_ff} + {1'b0, quo_ff};
   assign sat  = (|sum[32:16]) ? PENDING_MAX : sum[15:0];
   assign take = (sat != 16'd0);

   assign used   = {1'b0, elapsed_ff} + {17'd0, pending_ff};
   assign remain = (used >= {17'd0, interval_ff}) ? 16'd0 : (interval_ff - used[15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         mark_ff      <= '0;
         pending_ff   <= '0;
         interval_ff  <= INTERVAL_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            interval_ff <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
            pending_ff  <= '0;
         end
         if (cmd.exec) begin
            case (kind_ff)
               KIND_START: begin
                  running_ff <= 1'b1;
                  mark_ff    <= now_ff;
                  pending_ff <= 16'd1;
               end
               KIND_POLL: begin
                  if (running_ff && pending_ff != 16'd0) begin
                     pending_ff <= pending_ff - 16'd1;
                  end
               end
               KIND_STOP: begin
                  running_ff <= 1'b0;
               end
               KIND_CLEAR: begin
                  pending_ff <= '0;
               end
               default: begin
                  running_ff <= running_ff;
               end
            endcase
         end
         if (cmd.catch_up) begin
            pending_ff <= sat - {15'd0, take};
            mark_ff    <= now_ff - {16'd0, rem_ff};
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         now_ff  <= req_now_ms;
      end
      if (cmd.exec) begin
         send_ff <= (kind_ff == KIND_POLL) && running_ff && (pending_ff != 16'd0);
      end
      if (cmd.div_start) begin
         quo_ff <= elapsed_now;
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[30:0], rem_ge};
         rem_ff <= rem_ge ? rem_diff[15:0] : rem_sh[15:0];
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (cmd.catch_up) begin
         send_ff <= take;
      end
      if (cmd.measure) begin
         elapsed_ff <= elapsed_now;
      end
      if (cmd.publish) begin
         rsp_send_ff    <= send_ff;
         rsp_remain_ff  <= remain;
         rsp_pending_ff <= pending_ff;
      end
   end

   always_comb begin
      sts.kind       = kind_ff;
      sts.running    = running_ff;
      sts.pending_nz = (pending_ff != 16'd0);
      sts.overdue    = (elapsed_now > {16'd0, interval_ff});
      sts.div_last   = (cnt_ff == 5'(DIV_STEPS - 1));
      sts.out_busy   = rsp_valid_ff && rsp_stall;
   end

   assign interval          = interval_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_now      = rsp_send_ff;
   assign rsp_remaining_ms  = rsp_remain_ff;
   assign rsp_pending_slots = rsp_pending_ff;

endmodule

/* hw/rtl/cupt_checker.sv */
// Port-level checks for the pacing timer, bound to the top level.
`timescale 1ns / 1ps

module cupt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_send_now,
   input logic [15:0] rsp_remaining_ms,
   input logic [15:0] rsp_pending_slots
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_send_now)
         && $stable(rsp_remaining_ms) && $stable(rsp_pending_slots))
      else $error("result changed while stalled");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item taken while another in flight");

   // a fresh result follows a busy cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work");

   // a granted slot was taken from the queue, so it cannot be full
   a_send_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_now |-> rsp_pending_slots != 16'hFFFF)
      else $error("slot granted with saturated queue");

endmodule

bind catch_up_pacing_timer cupt_checker u_cupt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_send_now      (rsp_send_now),
   .rsp_remaining_ms  (rsp_remaining_ms),
   .rsp_pending_slots (rsp_pending_slots)
);

/* verif/pacing_slot_checker.sv */
// Slot-grant checker for the catch-up pacing timer: predicts every result item and compares it.
`timescale 1ns / 1ps

module pacing_slot_checker
   import cupt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_now_ms,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_send_now,
   input  logic [15:0] rsp_remaining_ms,
   input  logic [15:0] rsp_pending_slots,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int unsigned mismatches,
   output int unsigned grants_due
);

   typedef struct packed {
      logic        send_now;
      logic [15:0] remaining_ms;
      logic [15:0] pending_slots;
   } slot_grant_type;

   slot_grant_type due_grants[$];

   logic        timer_on;
   logic [31:0] mark_ms;
   logic [15:0] queued;
   logic [15:0] period_ms;

   // mark in the upper half and now in the lower: one short of the plain difference
   function automatic logic [31:0] span_ms(input logic [31:0] from_ms, input logic [31:0] to_ms);
      if (from_ms > HALF_RANGE && to_ms < HALF_RANGE) begin
         return 32'hFFFF_FFFF - from_ms + to_ms;
      end
      return to_ms - from_ms;
   endfunction

   function automatic slot_grant_type predict_slot(input logic [1:0] kind,
                                                   input logic [31:0] now_ms);
      logic [31:0] gap_ms;
      logic [32:0] owed;
      logic [32:0] used_ms;
      slot_grant_type grant;
      grant = '0;
      case (kind)
         KIND_START: begin
            timer_on = 1'b1;
            mark_ms  = now_ms;
            queued   = 16'd1;
         end
         KIND_POLL: begin
            // catch up only when nothing is queued
            if (timer_on && queued == 16'd0) begin
               gap_ms = span_ms(mark_ms, now_ms);
               if (gap_ms > {16'd0, period_ms}) begin
                  owed    = {1'b0, gap_ms / {16'd0, period_ms}} + {17'd0, queued};
                  queued  = (owed > {17'd0, PENDING_MAX}) ? PENDING_MAX : owed[15:0];
                  mark_ms = now_ms - gap_ms % {16'd0, period_ms};
               end
            end
            if (timer_on && queued != 16'd0) begin
               queued         = queued - 16'd1;
               grant.send_now = 1'b1;
            end
         end
         KIND_STOP: begin
            timer_on = 1'b0;
         end
         KIND_CLEAR: begin
            queued = 16'd0;
         end
         default: begin
            queued = queued;
         end
      endcase
      used_ms = {1'b0, span_ms(mark_ms, now_ms)} + {17'd0, queued};
      grant.remaining_ms  = (used_ms >= {17'd0, period_ms}) ? 16'd0 : period_ms - used_ms[15:0];
      grant.pending_slots = queued;
      return grant;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      slot_grant_type want;
      if (reset) begin
         timer_on   = 1'b0;
         mark_ms    = 32'd0;
         queued     = 16'd0;
         period_ms  = INTERVAL_RST;
         mismatches = 0;
         due_grants.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == {REG_INTERVAL, 2'b00}) begin
            period_ms = (csr_pwdata[15:0] == 16'd0) ? 16'd1 : csr_pwdata[15:0];
            queued    = 16'd0;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_grants.size() == 0) begin
               report_mismatch("result item with none expected");
            end else begin
               want = due_grants.pop_front();
               if (rsp_send_now !== want.send_now) begin
                  report_mismatch($sformatf("send_now %0d, expected %0d",
                                            rsp_send_now, want.send_now));
               end
               if (rsp_remaining_ms !== want.remaining_ms) begin
                  report_mismatch($sformatf("remaining_ms %0d, expected %0d",
                                            rsp_remaining_ms, want.remaining_ms));
               end
               if (rsp_pending_slots !== want.pending_slots) begin
                  report_mismatch($sformatf("pending_slots %0d, expected %0d",
                                            rsp_pending_slots, want.pending_slots));
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_grants.push_back(predict_slot(req_kind, req_now_ms));
         end
      end
      grants_due = due_grants.size();
   end

endmodule

/* verif/tb_catch_up_pacing_timer.sv */
// Testbench top for the catch-up pacing timer: stimulus, idling, register writes and verdict.
`timescale 1ns / 1ps

module tb_catch_up_pacing_timer
   import cupt_pkg::*;
();

   localparam int          HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int          SETTLE_CYCLES = 40;    // worst item latency, with margin
   localparam int          PHASE_ITEMS   = 230;   // random items per interval setting
   localparam int          PHASES        = 8;
   localparam longint      LIMIT_NS      = 20_000_000;
   localparam logic [2:0]  INTERVAL_ADDR = {REG_INTERVAL, 2'b00};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_send_now;
   logic [15:0] rsp_remaining_ms;
   logic [15:0] rsp_pending_slots;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int unsigned mismatches;
   int unsigned grants_due;

   // idling control for the sender and the receiver
   bit          hold_rsp    = 1'b0;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;

   // free-running millisecond clock of the well-formed traffic, and whether the
   // last start has not been followed by a stop
   logic [31:0] wall_ms;
   bit          timer_live;

   catch_up_pacing_timer DUT (.*);

   pacing_slot_checker slot_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

   // Receiver: random stall bursts at the current rate; a requested hold-off
   // keeps the result channel blocked long enough for the input to back up.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            hold_rsp  = 1'b0;
         end else if ($urandom_range(0, 99) < rx_idle_pct) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // Offer one item from a falling edge, hold it until taken, return on a falling edge.
   task automatic offer_item(input logic [1:0] kind, input logic [31:0] stamp);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid  = 1'b1;
      req_kind   = kind;
      req_now_ms = stamp;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      if (kind == KIND_START) begin
         timer_live = 1'b1;
      end else if (kind == KIND_STOP) begin
         timer_live = 1'b0;
      end
   endtask

   // Interval write: only once every result is back and the block has settled.
   // Upper data bits are random; only the low 16 count.
   task automatic write_interval(input logic [15:0] value);
      while (grants_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = INTERVAL_ADDR;
      csr_pwdata  = {16'($urandom_range(0, 65535)), value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Mostly well-formed traffic: start, then polls on an advancing clock, with
   // the odd stop and clear. Steps range from none to several intervals, now
   // and then a long absence or a jump anywhere. A small share is noise with
   // random kind and random time.
   task automatic run_traffic(input int count, input int hold_at, input logic [31:0] p_ms);
      int          pick;
      int          sel;
      logic [31:0] step_ms;
      logic [1:0]  kind;
      logic [31:0] stamp;
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) begin
            hold_rsp = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            kind  = 2'($urandom_range(0, 3));
            stamp = $urandom();
         end else begin
            if ((!timer_live && pick < 50) || pick < 12) begin
               kind = KIND_START;
            end else if (pick < 16) begin
               kind = KIND_STOP;
            end else if (pick < 20) begin
               kind = KIND_CLEAR;
            end else begin
               kind = KIND_POLL;
            end
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
               step_ms = 32'd0;
            end else if (sel < 60) begin
               step_ms = $urandom_range(0, p_ms);
            end else if (sel < 90) begin
               step_ms = $urandom_range(p_ms, 4 * p_ms + 1);
            end else if (sel < 97) begin
               step_ms = $urandom_range(0, 200 * p_ms);
            end else begin
               step_ms = $urandom();
            end
            wall_ms = wall_ms + step_ms;
            stamp   = wall_ms;
         end
         offer_item(kind, stamp);
      end
   endtask

   initial begin
      logic [15:0] iv;
      req_valid   = 1'b0;
      req_kind    = KIND_POLL;
      req_now_ms  = 32'd0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = INTERVAL_ADDR;
      csr_pwdata  = 32'd0;
      wall_ms     = 32'd0;
      timer_live  = 1'b0;
      reset       = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed part, reset interval of 20 ms, no idling ---
      // stopped timer: poll, clear and stop all give nothing
      offer_item(KIND_POLL,  32'h0000_0000);
      offer_item(KIND_CLEAR, 32'hFFFF_FFFF);
      offer_item(KIND_STOP,  32'h1234_5678);
      // start near the top, then polls across the wrap of the millisecond clock
      offer_item(KIND_START, 32'hFFFF_FFF0);
      offer_item(KIND_POLL,  32'hFFFF_FFF0);   // immediate slot
      offer_item(KIND_POLL,  32'h0000_0004);   // 19 ms by the wrap rule
      offer_item(KIND_POLL,  32'h0000_0005);   // exactly one interval: no slot yet
      offer_item(KIND_POLL,  32'h0000_0006);   // just over: one slot
      offer_item(KIND_POLL,  32'h0000_03E8);   // catch-up of many slots
      offer_item(KIND_STOP,  32'h0000_03E9);
      offer_item(KIND_POLL,  32'h0001_0000);   // poll while stopped, remaining still worked out
      // mark on the half-range boundary: plain difference, huge elapsed
      offer_item(KIND_START, 32'h7FFF_FFFF);
      offer_item(KIND_POLL,  32'h7FFF_FFFF);
      offer_item(KIND_POLL,  32'h7FFF_FFFE);   // pending count saturates
      offer_item(KIND_CLEAR, 32'h8000_0000);
      // mark in the upper half, now in the lower half
      offer_item(KIND_START, 32'h8000_0000);
      offer_item(KIND_POLL,  32'h7FFF_FFFE);
      offer_item(KIND_START, 32'h0000_0000);
      offer_item(KIND_POLL,  32'hFFFF_FFFF);   // largest elapsed
      // zero interval is taken as 1 ms
      write_interval(16'd0);
      offer_item(KIND_START, 32'd100);
      offer_item(KIND_POLL,  32'd100);
      offer_item(KIND_POLL,  32'd70100);       // 70000 slots owed, saturates
      // longest interval
      write_interval(16'hFFFF);
      offer_item(KIND_START, 32'd0);
      offer_item(KIND_POLL,  32'd0);
      offer_item(KIND_POLL,  32'd65536);

      // --- random part: one interval setting per phase, extremes included ---
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin iv = 16'd1;                         tx_idle_pct = 10; rx_idle_pct = 10; end
            1: begin iv = 16'hFFFF;                      tx_idle_pct = 20; rx_idle_pct = 30; end
            2: begin iv = INTERVAL_RST;                  tx_idle_pct = 0;  rx_idle_pct = 0;  end
            3: begin iv = 16'($urandom_range(2, 64));    tx_idle_pct = 40; rx_idle_pct = 5;  end
            4: begin iv = 16'($urandom_range(65, 5000)); tx_idle_pct = 5;  rx_idle_pct = 40; end
            5: begin iv = 16'($urandom());               tx_idle_pct = 15; rx_idle_pct = 15; end
            6: begin iv = 16'd0;                         tx_idle_pct = 30; rx_idle_pct = 30; end
            default: begin
               // closing stretch runs flat out on both sides
               iv = 16'($urandom_range(2, 300));
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         write_interval(iv);
         wall_ms = $urandom();
         // the long hold-off falls in the second phase, with items still offered
         run_traffic(PHASE_ITEMS, (ph == 1) ? 60 : -1, (iv == 16'd0) ? 32'd1 : {16'd0, iv});
      end

      // drain, then allow for a stray late result
      while (grants_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* catch_up_pacing_timer.f */
hw/rtl/cupt_pkg.sv
hw/rtl/cupt_ctrl.sv
hw/rtl/cupt_dp.sv
hw/rtl/catch_up_pacing_timer.sv
hw/rtl/cupt_checker.sv
verif/pacing_slot_checker.sv
verif/tb_catch_up_pacing_timer.sv
